/* sv/nnsf_pkg.sv */
package nnsf_pkg;

  localparam int unsigned SIZE_W      = 12;
  localparam int unsigned STEP_W      = 24;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned FILL_SIZE_W = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam int unsigned DEF_MAX_SOURCE_SIZE    = 2048;
  localparam int unsigned DEF_MAX_DEST_SIZE      = 4095;
  localparam int unsigned DEF_STEP_FRACTION_BITS = 16;

  localparam int unsigned RST_SRC_SIZE  = 2048;
  localparam int unsigned RST_DEST_SIZE = 2048;
  localparam int unsigned RST_STEP      = 65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_DEST_WIDTH  = 3'd2,
    REG_DEST_HEIGHT = 3'd3,
    REG_STEP_X      = 3'd4,
    REG_STEP_Y      = 3'd5
  } cfg_reg_t;

  // sizes are held already clipped to the configured maxima, ceilings precomputed
  typedef struct packed {
    logic [SIZE_W-1:0]      sw;
    logic [SIZE_W-1:0]      sh;
    logic [SIZE_W-1:0]      dw;
    logic [SIZE_W-1:0]      dh;
    logic [STEP_W-1:0]      step_x;
    logic [STEP_W-1:0]      step_y;
    logic [FILL_SIZE_W-1:0] ceil_x;
    logic [FILL_SIZE_W-1:0] ceil_y;
  } cfg_t;

  typedef struct packed {
    logic [SIZE_W-1:0]      x;
    logic [SIZE_W-1:0]      y;
    logic [FILL_SIZE_W-1:0] w;
    logic [FILL_SIZE_W-1:0] h;
    logic [COLOR_W-1:0]     color;
  } fill_t;

endpackage

/* sv/nearest_neighbor_scale_fill.sv */
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+-------------------------------------------
// in       | in        | in_valid / in_ready   | pixel_color, frame_start
// out      | out       | out_valid / out_ready | fill_x, fill_y, fill_width, fill_height,
//          |           |                       | fill_color
// cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel per cycle while in_ready is high; a pixel that yields a fill reaches out_valid
// through the input register, then the result register. The per-pixel position add, edge compares
// and clip sit between those two registers.
// Reset is synchronous; it restores the register defaults and starts a fresh frame.
// A stalled result holds in the output register; in_ready drops only when both
// registers are full and out_ready is low. cfg_ready is always high.
module nearest_neighbor_scale_fill #(
  parameter int unsigned MAX_SOURCE_SIZE    = nnsf_pkg::DEF_MAX_SOURCE_SIZE,
  parameter int unsigned MAX_DEST_SIZE      = nnsf_pkg::DEF_MAX_DEST_SIZE,
  parameter int unsigned STEP_FRACTION_BITS = nnsf_pkg::DEF_STEP_FRACTION_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [nnsf_pkg::COLOR_W-1:0]       pixel_color,
  input  logic                               frame_start,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [nnsf_pkg::SIZE_W-1:0]        fill_x,
  output logic [nnsf_pkg::SIZE_W-1:0]        fill_y,
  output logic [nnsf_pkg::FILL_SIZE_W-1:0]   fill_width,
  output logic [nnsf_pkg::FILL_SIZE_W-1:0]   fill_height,
  output logic [nnsf_pkg::COLOR_W-1:0]       fill_color,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nnsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nnsf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import nnsf_pkg::*;

  cfg_t  cfg;
  fill_t fill_calc;
  fill_t fill_q;
  logic  load;
  logic  space;

  nnsf_cfg_regs #(
    .MAX_SOURCE_SIZE    (MAX_SOURCE_SIZE),
    .MAX_DEST_SIZE      (MAX_DEST_SIZE),
    .STEP_FRACTION_BITS (STEP_FRACTION_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  nnsf_scaler #(
    .MAX_SOURCE_SIZE    (MAX_SOURCE_SIZE),
    .STEP_FRACTION_BITS (STEP_FRACTION_BITS)
  ) u_scaler (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_color (pixel_color),
    .frame_start (frame_start),
    .cfg         (cfg),
    .space       (space),
    .load        (load),
    .fill        (fill_calc)
  );

  nnsf_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .fill_in   (fill_calc),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .fill      (fill_q)
  );

  assign fill_x      = fill_q.x;
  assign fill_y      = fill_q.y;
  assign fill_width  = fill_q.w;
  assign fill_height = fill_q.h;
  assign fill_color  = fill_q.color;

endmodule

/* sv/nnsf_cfg_regs.sv */
module nnsf_cfg_regs #(
  parameter int unsigned MAX_SOURCE_SIZE    = nnsf_pkg::DEF_MAX_SOURCE_SIZE,
  parameter int unsigned MAX_DEST_SIZE      = nnsf_pkg::DEF_MAX_DEST_SIZE,
  parameter int unsigned STEP_FRACTION_BITS = nnsf_pkg::DEF_STEP_FRACTION_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nnsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nnsf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output nnsf_pkg::cfg_t                    cfg
);
  import nnsf_pkg::*;

  typedef logic [STEP_W:0] step_ext_t;

  localparam longint unsigned ROUND    = (64'd1 << STEP_FRACTION_BITS) - 64'd1;
  localparam int unsigned     FILL_MAX = (1 << FILL_SIZE_W) - 1;

  function automatic logic [SIZE_W-1:0] clip(input logic [SIZE_W-1:0] v,
                                             input int unsigned lim);
    return (32'(v) > lim) ? SIZE_W'(lim) : v;
  endfunction

  function automatic logic [FILL_SIZE_W-1:0] ceil_step(input logic [STEP_W-1:0] s);
    step_ext_t sum;
    step_ext_t c;
    sum = step_ext_t'(s) + step_ext_t'(ROUND);
    c   = sum >> STEP_FRACTION_BITS;
    return (32'(c) > FILL_MAX) ? FILL_SIZE_W'(FILL_MAX) : FILL_SIZE_W'(c);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sw     <= clip(SIZE_W'(RST_SRC_SIZE), MAX_SOURCE_SIZE);
      cfg.sh     <= clip(SIZE_W'(RST_SRC_SIZE), MAX_SOURCE_SIZE);
      cfg.dw     <= clip(SIZE_W'(RST_DEST_SIZE), MAX_DEST_SIZE);
      cfg.dh     <= clip(SIZE_W'(RST_DEST_SIZE), MAX_DEST_SIZE);
      cfg.step_x <= STEP_W'(RST_STEP);
      cfg.step_y <= STEP_W'(RST_STEP);
      cfg.ceil_x <= ceil_step(STEP_W'(RST_STEP));
      cfg.ceil_y <= ceil_step(STEP_W'(RST_STEP));
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:   cfg.sw <= clip(cfg_data[SIZE_W-1:0], MAX_SOURCE_SIZE);
        REG_SRC_HEIGHT:  cfg.sh <= clip(cfg_data[SIZE_W-1:0], MAX_SOURCE_SIZE);
        REG_DEST_WIDTH:  cfg.dw <= clip(cfg_data[SIZE_W-1:0], MAX_DEST_SIZE);
        REG_DEST_HEIGHT: cfg.dh <= clip(cfg_data[SIZE_W-1:0], MAX_DEST_SIZE);
        REG_STEP_X: begin
          cfg.step_x <= cfg_data[STEP_W-1:0];
          cfg.ceil_x <= ceil_step(cfg_data[STEP_W-1:0]);
        end
        REG_STEP_Y: begin
          cfg.step_y <= cfg_data[STEP_W-1:0];
          cfg.ceil_y <= ceil_step(cfg_data[STEP_W-1:0]);
        end
        default: ;
      endcase
    end
  end

endmodule

/* sv/nnsf_scaler.sv */
module nnsf_scaler #(
  parameter int unsigned MAX_SOURCE_SIZE    = nnsf_pkg::DEF_MAX_SOURCE_SIZE,
  parameter int unsigned STEP_FRACTION_BITS = nnsf_pkg::DEF_STEP_FRACTION_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [nnsf_pkg::COLOR_W-1:0]    pixel_color,
  input  logic                            frame_start,
  input  nnsf_pkg::cfg_t                  cfg,
  input  logic                            space,
  output logic                            load,
  output nnsf_pkg::fill_t                 fill
);
  import nnsf_pkg::*;

  localparam int unsigned COL_W = (MAX_SOURCE_SIZE > 1) ? $clog2(MAX_SOURCE_SIZE) : 1;
  localparam int unsigned ROW_W = $clog2(MAX_SOURCE_SIZE + 1);
  localparam int unsigned POS_W = COL_W + STEP_W;
  localparam int unsigned INT_W = POS_W - STEP_FRACTION_BITS;

  // input register
  logic               s1_valid;
  logic [COLOR_W-1:0] s1_color;
  logic               s1_fs;
  logic               adv;

  // frame state
  logic [COL_W-1:0]   col_cnt, col_cnt_next;
  logic [ROW_W-1:0]   row_cnt, row_cnt_next;
  logic [POS_W-1:0]   col_pos, col_pos_next;
  logic [POS_W-1:0]   row_pos, row_pos_next;
  logic [SIZE_W-1:0]  last_col, last_col_next;
  logic               last_col_vld, last_col_vld_next;
  logic [SIZE_W-1:0]  last_row, last_row_next;
  logic               last_row_vld, last_row_vld_next;
  logic               row_kept, row_kept_next;

  logic [COL_W-1:0]   cc;
  logic [ROW_W-1:0]   rc;
  logic [POS_W-1:0]   cp, rp;
  logic [INT_W-1:0]   col_int, row_int;
  logic [SIZE_W-1:0]  col_int_s, row_int_s;
  logic               col0, row_ok, new_row, kept, col_ok, emit, wrap;
  logic [SIZE_W-1:0]  lc, lr;
  logic               lc_vld, lr_vld;
  logic [SIZE_W-1:0]  w_room;
  logic [SIZE_W:0]    h_room;

  assign adv      = s1_valid && space;
  assign in_ready = !s1_valid || adv;
  assign load     = adv && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_color <= pixel_color;
      s1_fs    <= frame_start;
    end
  end

  always_comb begin
    // a frame start clears everything before the pixel is handled
    cc     = s1_fs ? '0 : col_cnt;
    rc     = s1_fs ? '0 : row_cnt;
    cp     = s1_fs ? '0 : col_pos;
    rp     = s1_fs ? '0 : row_pos;
    lr     = last_row;
    lr_vld = s1_fs ? 1'b0 : last_row_vld;

    col_int   = cp[POS_W-1:STEP_FRACTION_BITS];
    row_int   = rp[POS_W-1:STEP_FRACTION_BITS];
    col_int_s = SIZE_W'(col_int);
    row_int_s = SIZE_W'(row_int);

    col0    = (cc == '0);
    row_ok  = (64'(rc) < 64'(cfg.sh)) && (64'(row_int) < 64'(cfg.dh));
    new_row = col0 && row_ok && (!lr_vld || (lr != row_int_s));
    kept    = col0 ? new_row : (s1_fs ? 1'b0 : row_kept);

    last_row_next     = new_row ? row_int_s : lr;
    last_row_vld_next = new_row ? 1'b1 : lr_vld;
    lc                = last_col;
    lc_vld            = (s1_fs || new_row) ? 1'b0 : last_col_vld;

    col_ok = kept && (32'(cc) < 32'(cfg.sw)) && (64'(col_int) < 64'(cfg.dw));
    emit   = col_ok && (!lc_vld || (lc != col_int_s));

    last_col_next     = emit ? col_int_s : lc;
    last_col_vld_next = emit ? 1'b1 : lc_vld;
    row_kept_next     = kept;

    // height shrunk under a kept row leaves the room negative: no clip then
    w_room     = cfg.dw - col_int_s;
    h_room     = {1'b0, cfg.dh} - {1'b0, last_row_next};
    fill.x     = col_int_s;
    fill.y     = last_row_next;
    fill.w     = (SIZE_W'(cfg.ceil_x) > w_room) ? FILL_SIZE_W'(w_room) : cfg.ceil_x;
    fill.h     = (!h_room[SIZE_W] && ((SIZE_W+1)'(cfg.ceil_y) > h_room)) ?
                 FILL_SIZE_W'(h_room) : cfg.ceil_y;
    fill.color = s1_color;

    // a count at or past the last source column wraps to the next row (row count held at MAX_SOURCE_SIZE)
    wrap = (32'(cc) + 32'd1) >= 32'(cfg.sw);
    if (wrap) begin
      col_cnt_next = '0;
      col_pos_next = '0;
      if (32'(rc) < MAX_SOURCE_SIZE) begin
        row_cnt_next = rc + ROW_W'(1);
        row_pos_next = rp + POS_W'(cfg.step_y);
      end else begin
        row_cnt_next = rc;
        row_pos_next = rp;
      end
    end else begin
      col_cnt_next = cc + COL_W'(1);
      col_pos_next = cp + POS_W'(cfg.step_x);
      row_cnt_next = rc;
      row_pos_next = rp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt      <= '0;
      row_cnt      <= '0;
      col_pos      <= '0;
      row_pos      <= '0;
      last_col     <= '0;
      last_col_vld <= 1'b0;
      last_row     <= '0;
      last_row_vld <= 1'b0;
      row_kept     <= 1'b0;
    end else if (adv) begin
      col_cnt      <= col_cnt_next;
      row_cnt      <= row_cnt_next;
      col_pos      <= col_pos_next;
      row_pos      <= row_pos_next;
      last_col     <= last_col_next;
      last_col_vld <= last_col_vld_next;
      last_row     <= last_row_next;
      last_row_vld <= last_row_vld_next;
      row_kept     <= row_kept_next;
    end
  end

endmodule

/* sv/nnsf_out_reg.sv */
module nnsf_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  nnsf_pkg::fill_t fill_in,
  output logic            space,
  output logic            out_valid,
  input  logic            out_ready,
  output nnsf_pkg::fill_t fill
);
  import nnsf_pkg::*;

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fill <= fill_in;
    end
  end

endmodule

/* sv/nnsf_checker.sv */
module nnsf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [nnsf_pkg::COLOR_W-1:0]      pixel_color,
  input logic                              frame_start,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [nnsf_pkg::SIZE_W-1:0]       fill_x,
  input logic [nnsf_pkg::SIZE_W-1:0]       fill_y,
  input logic [nnsf_pkg::FILL_SIZE_W-1:0]  fill_width,
  input logic [nnsf_pkg::FILL_SIZE_W-1:0]  fill_height,
  input logic [nnsf_pkg::COLOR_W-1:0]      fill_color,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [nnsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [nnsf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import nnsf_pkg::*;

  // a waiting rectangle must not change under a stall
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fill_x) && $stable(fill_y)
      && $stable(fill_width) && $stable(fill_height) && $stable(fill_color))
    else $error("result changed while stalled");

  // nothing left over from before reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // an empty result register never stalls the input side
  a_no_bubble: assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // the top-left corner always lies inside a destination of at most 4095
  a_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_x != {SIZE_W{1'b1}}) && (fill_y != {SIZE_W{1'b1}}))
    else $error("corner outside destination");

endmodule

bind nearest_neighbor_scale_fill nnsf_checker u_nnsf_checker (.*);

/* dv/tb_top.sv */
module tb_top;
  import nnsf_pkg::*;

  localparam int unsigned MAX_SRC      = DEF_MAX_SOURCE_SIZE;
  localparam int unsigned MAX_DST      = DEF_MAX_DEST_SIZE;
  localparam int unsigned FRAC         = DEF_STEP_FRACTION_BITS;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam logic signed [12:0] NO_SPOT = -13'sd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               first;
  } pixel_req_t;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic [COLOR_W-1:0]     pixel_color = '0;
  logic                   frame_start = 1'b0;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic [SIZE_W-1:0]      fill_x;
  logic [SIZE_W-1:0]      fill_y;
  logic [FILL_SIZE_W-1:0] fill_width;
  logic [FILL_SIZE_W-1:0] fill_height;
  logic [COLOR_W-1:0]     fill_color;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;

  // scaler model state and register copy
  logic [SIZE_W-1:0]  r_src_w, r_src_h, r_dst_w, r_dst_h;
  logic [STEP_W-1:0]  r_step_x, r_step_y;
  logic [11:0]        col_cnt, row_cnt;
  logic [34:0]        col_pos, row_pos;
  logic signed [12:0] last_col, last_row;
  logic               row_on;

  pixel_req_t  pixels_pending [$];
  fill_t       fills_due [$];
  int unsigned send_idle_pct = 8;
  int unsigned take_idle_pct = 84;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  nearest_neighbor_scale_fill u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned at_most(input int unsigned v, input int unsigned m);
    return v < m ? v : m;
  endfunction

  function automatic int unsigned step_ceiling(input logic [STEP_W-1:0] s);
    int unsigned c;
    c = (32'(s) + ((32'd1 << FRAC) - 1)) >> FRAC;
    return at_most(c, 255);
  endfunction

  task automatic clear_frame();
    col_cnt  = '0;
    row_cnt  = '0;
    col_pos  = '0;
    row_pos  = '0;
    last_col = NO_SPOT;
    last_row = NO_SPOT;
    row_on   = 1'b0;
  endtask

  task automatic scale_pixel(input logic [COLOR_W-1:0] color, input logic first);
    int unsigned sw, sh, dw, dh, x;
    logic [34:0] dw_fix, dh_fix;
    logic signed [12:0] spot;
    fill_t f;
    sw = at_most(32'(r_src_w), MAX_SRC);
    sh = at_most(32'(r_src_h), MAX_SRC);
    dw = at_most(32'(r_dst_w), MAX_DST);
    dh = at_most(32'(r_dst_h), MAX_DST);
    dw_fix = 35'(dw) << FRAC;
    dh_fix = 35'(dh) << FRAC;
    if (first) clear_frame();
    // row decision taken at every column-0 pixel
    if (col_cnt == 0) begin
      row_on = 1'b0;
      spot = {1'b0, row_pos[FRAC +: SIZE_W]};
      if (row_cnt < sh && row_pos < dh_fix && spot != last_row) begin
        row_on   = 1'b1;
        last_row = spot;
        last_col = NO_SPOT;
      end
    end
    spot = {1'b0, col_pos[FRAC +: SIZE_W]};
    if (row_on && col_cnt < sw && col_pos < dw_fix && spot != last_col) begin
      x       = 32'(col_pos[FRAC +: SIZE_W]);
      f.x     = SIZE_W'(x);
      f.y     = last_row[SIZE_W-1:0];
      // a height that shrank under a kept row leaves no room to clip against
      f.w     = FILL_SIZE_W'(at_most(step_ceiling(r_step_x), dw - x));
      f.h     = FILL_SIZE_W'(at_most(step_ceiling(r_step_y),
                                     dh - 32'(last_row[SIZE_W-1:0])));
      f.color = color;
      last_col = spot;
      fills_due.push_back(f);
    end
    if (col_cnt + 1 >= sw) begin
      col_cnt = '0;
      col_pos = '0;
      if (row_cnt < MAX_SRC) begin
        row_cnt = row_cnt + 1'b1;
        row_pos = row_pos + r_step_y;
      end
    end else begin
      col_cnt = col_cnt + 1'b1;
      col_pos = col_pos + r_step_x;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // pixel request driver
  always @(posedge clk) begin : feed
    pixel_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) scale_pixel(pixel_color, frame_start);
      if (!in_valid || in_ready) begin
        if (pixels_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pixels_pending.pop_front();
          in_valid    <= 1'b1;
          pixel_color <= nxt.color;
          frame_start <= nxt.first;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // fill command monitor
  always @(posedge clk) begin : watch
    fill_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (fills_due.size() == 0) begin
          report_mismatch($sformatf("unexpected fill x=%0d y=%0d w=%0d h=%0d c=%h",
                                    fill_x, fill_y, fill_width, fill_height, fill_color));
        end else begin
          want = fills_due.pop_front();
          if (fill_x !== want.x)
            report_mismatch($sformatf("fill_x got %0d want %0d", fill_x, want.x));
          if (fill_y !== want.y)
            report_mismatch($sformatf("fill_y got %0d want %0d", fill_y, want.y));
          if (fill_width !== want.w)
            report_mismatch($sformatf("fill_width got %0d want %0d", fill_width, want.w));
          if (fill_height !== want.h)
            report_mismatch($sformatf("fill_height got %0d want %0d", fill_height, want.h));
          if (fill_color !== want.color)
            report_mismatch($sformatf("fill_color got %h want %h", fill_color, want.color));
        end
      end
      out_ready <= $urandom_range(99) >= take_idle_pct;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nearest_neighbor_scale_fill regression: fail");
      $finish;
    end
  end

  task automatic push_pixel(input logic [COLOR_W-1:0] color, input logic first);
    pixel_req_t px;
    px.color = color;
    px.first = first;
    pixels_pending.push_back(px);
  endtask

  task automatic wait_idle();
    while (pixels_pending.size() != 0 || in_valid || fills_due.size() != 0)
      @(posedge clk);
    // a pixel with no fill may still be in the pipe
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes all six registers, then now and again an unused index
  task automatic program_regs(input logic [SIZE_W-1:0] sw, sh, dw, dh,
                              input logic [STEP_W-1:0] sx, sy);
    logic [CFG_DATA_W-1:0] vals [7];
    logic [CFG_IDX_W-1:0]  order [7];
    int unsigned           count;
    order = '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DEST_WIDTH, REG_DEST_HEIGHT,
              REG_STEP_X, REG_STEP_Y, REG_SPARE_LO};
    // upper bits of size writes are don't-care
    vals[0] = {12'($urandom()), sw};
    vals[1] = {12'($urandom()), sh};
    vals[2] = {12'($urandom()), dw};
    vals[3] = {12'($urandom()), dh};
    vals[4] = sx;
    vals[5] = sy;
    vals[6] = CFG_DATA_W'($urandom());
    if ($urandom_range(1)) order[6] = REG_SPARE_HI;
    count = $urandom_range(2) == 0 ? 7 : 6;
    for (int i = 0; i < count; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (order[i])
        REG_SRC_WIDTH:   r_src_w  = vals[i][SIZE_W-1:0];
        REG_SRC_HEIGHT:  r_src_h  = vals[i][SIZE_W-1:0];
        REG_DEST_WIDTH:  r_dst_w  = vals[i][SIZE_W-1:0];
        REG_DEST_HEIGHT: r_dst_h  = vals[i][SIZE_W-1:0];
        REG_STEP_X:      r_step_x = vals[i][STEP_W-1:0];
        REG_STEP_Y:      r_step_y = vals[i][STEP_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [STEP_W-1:0] random_step();
    case ($urandom_range(9))
      0, 1, 2: return STEP_W'($urandom_range(1 << FRAC, 4 << FRAC));
      3, 4, 5: return STEP_W'($urandom_range(1 << (FRAC - 2), 1 << FRAC));
      6:       return STEP_W'($urandom_range(1, 3)) << FRAC;
      7:       return STEP_W'($urandom());
      8:       return '0;
      default: return '1;
    endcase
  endfunction

  // destination size as software would set it, with some arbitrary ones mixed in
  function automatic logic [SIZE_W-1:0] fitted_dest(input logic [SIZE_W-1:0] size,
                                                    input logic [STEP_W-1:0] step);
    longint unsigned span;
    if ($urandom_range(4) == 0) return SIZE_W'($urandom_range(0, MAX_DST));
    span = (64'(size) * 64'(step) + 64'((1 << FRAC) - 1)) >> FRAC;
    return SIZE_W'(at_most(32'(span < 1 ? 1 : span), MAX_DST));
  endfunction

  // mostly whole frames; some cut short, some stray pixels with no frame start
  task automatic queue_frames(input int unsigned quota, input int unsigned cols,
                              input int unsigned rows);
    int unsigned made, len, roll;
    made = 0;
    while (made < quota) begin
      roll = $urandom_range(99);
      len  = (cols == 0 ? 1 : cols) * (rows == 0 ? 1 : rows);
      if (roll < 12) len = $urandom_range(1, len);
      else if (roll >= 92) len = $urandom_range(1, 4);
      for (int unsigned k = 0; k < len && made < quota; k++) begin
        push_pixel($urandom(), k == 0 && roll < 92);
        made++;
      end
    end
  endtask

  initial begin : stimulus
    logic [SIZE_W-1:0] sw, sh;
    logic [STEP_W-1:0] sx, sy;
    int unsigned       quota;
    clear_frame();
    r_src_w  = SIZE_W'(RST_SRC_SIZE);
    r_src_h  = SIZE_W'(RST_SRC_SIZE);
    r_dst_w  = SIZE_W'(RST_DEST_SIZE);
    r_dst_h  = SIZE_W'(RST_DEST_SIZE);
    r_step_x = STEP_W'(RST_STEP);
    r_step_y = STEP_W'(RST_STEP);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset
    push_pixel('0, 1'b1);
    push_pixel('1, 1'b0);
    push_pixel($urandom(), 1'b0);
    wait_idle();

    // 1.5x by 2x, right and bottom clip, a pixel past the last row, early frame start
    program_regs(12'd4, 12'd2, 12'd5, 12'd3, 24'h018000, 24'h020000);
    for (int k = 0; k < 9; k++) push_pixel($urandom(), k == 0);
    push_pixel($urandom(), 1'b1);
    push_pixel($urandom(), 1'b0);
    wait_idle();

    // change mid-row, widest step with clip, zero vertical step repeats row 0
    program_regs(12'd3, 12'd3, 12'd300, 12'd4095, 24'hFFFFFF, 24'h000000);
    repeat (4) push_pixel($urandom(), 1'b0);
    for (int k = 0; k < 3; k++) push_pixel($urandom(), k == 0);
    wait_idle();

    // zero destination width: nothing comes out
    program_regs(12'd2, 12'd2, 12'd0, 12'd2, 24'h010000, 24'h010000);
    for (int k = 0; k < 4; k++) push_pixel($urandom(), k == 0);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      send_idle_pct = ph < 3 ? 8 : (ph < 6 ? 84 : 0);
      take_idle_pct = ph < 3 ? 84 : (ph < 6 ? 8 : 0);
      quota = 125;
      if (ph == 2) begin
        // oversized source is clamped
        sw = '1;
        sh = 12'd2048;
        quota = 60;
        program_regs(sw, sh, '1, '1, '1, 24'hFF0000);
      end else if (ph == 5) begin
        sw = 12'd1;
        sh = 12'd1;
        quota = 60;
        program_regs(sw, sh, 12'd1, 12'd1, 24'd1, 24'd1);
      end else begin
        sw = SIZE_W'($urandom_range(1, 12));
        sh = SIZE_W'($urandom_range(1, 10));
        if ($urandom_range(15) == 0) sw = '0;
        if ($urandom_range(15) == 0) sh = '0;
        sx = random_step();
        sy = random_step();
        program_regs(sw, sh, fitted_dest(sw, sx), fitted_dest(sh, sy), sx, sy);
      end
      queue_frames(quota, sw, sh);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("nearest_neighbor_scale_fill regression: pass");
    end else begin
      $display("nearest_neighbor_scale_fill regression: fail");
    end
    $finish;
  end

endmodule
